// ===== hdl/alm_pkg.sv =====
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants for the level meter ballistics
// Field widths, dB conversion constants, and the command/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package alm_pkg;

	// channel count and indexing
	localparam int CHANNELS   = 64;
	localparam int CHAN_W     = 6;
	localparam int CHAN_CMP_W = CHAN_W + 1;
	localparam int IDX_W      = $clog2(CHANNELS);

	// field widths
	localparam int LVL_W   = 24;
	localparam int COEFF_W = 16;
	localparam int DB_W    = 16;

	// log2 unit widths
	localparam int FRAC_W     = 16;
	localparam int SH_W       = 5;
	localparam int LG_W       = SH_W + 1 + FRAC_W;
	localparam int K_W        = 27;
	localparam int PROD_W     = LG_W + K_W + 1;
	localparam int RND_W      = PROD_W + 1;
	localparam int RND_SHIFT  = 32;
	localparam int DBF_W      = RND_W - RND_SHIFT;
	localparam int SQ_STEPS   = FRAC_W;
	localparam int SQ_CNT_W   = $clog2(SQ_STEPS);

	// 20*log10(2)*256 in Q16
	localparam logic [K_W-1:0] DB_K = K_W'(101008905);

	// display limits in 1/256 dB
	localparam int DB_FLOOR = -25600;
	localparam int DB_CEIL  = 1541;

	localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(5240);

	// opcodes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// per-channel envelope word
	typedef struct packed {
		logic             clip;
		logic [LVL_W-1:0] rms;
		logic [LVL_W-1:0] peak;
	} alm_env_t;

	// controller commands
	typedef struct packed {
		logic accept;
		logic upd;
		logic norm;
		logic sq;
		logic mul;
		logic fin;
	} alm_cmd_t;

	// datapath status
	typedef struct packed {
		logic norm_done;
		logic out_room;
	} alm_sts_t;

endpackage

// ===== hdl/alm_log_unit.sv =====
// ----------------------------------------------------------------------------
// alm_log_unit: linear level to 1/256 dB converter
// Normalizes in coarse shift steps, extracts the log2 fraction one bit per
// squaring, then scales by 20*log10(2) with round-half-up and saturation.
// ----------------------------------------------------------------------------
module alm_log_unit import alm_pkg::*; (
	input  logic                   clk,
	input  alm_cmd_t               cmd,
	input  logic [LVL_W-1:0]       load_val,
	output logic                   done,
	output logic signed [DB_W-1:0] db
);

	logic [LVL_W-1:0]         m_q;
	logic [SH_W-1:0]          sh_q;
	logic [FRAC_W-1:0]        frac_q;
	logic                     zero_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [2*LVL_W-1:0]       m_sq;
	logic [LVL_W:0]           m_nx;
	logic signed [LG_W-1:0]   lg;
	logic signed [K_W:0]      k_s;
	logic signed [RND_W-1:0]  rnd_sum;
	logic signed [DBF_W-1:0]  db_full;

	assign done = m_q[LVL_W-1] | zero_q;

	// squaring step: Q1.23 times Q1.23, truncated back to Q2.23
	assign m_sq = (2*LVL_W)'(m_q) * (2*LVL_W)'(m_q);
	assign m_nx = m_sq[2*LVL_W-1:LVL_W-1];

	// log2 in Q.16: integer part is minus the normalizing shift
	assign lg  = {(SH_W+1)'(0) - {1'b0, sh_q}, frac_q};
	assign k_s = {1'b0, DB_K};

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			m_q    <= load_val;
			sh_q   <= '0;
			frac_q <= '0;
			zero_q <= (load_val == '0);
		end else if (cmd.norm && !done) begin
			// leading-zero search, coarse to fine
			if (m_q[LVL_W-1:LVL_W-8] == '0) begin
				m_q  <= {m_q[LVL_W-9:0], 8'd0};
				sh_q <= sh_q + SH_W'(8);
			end else if (m_q[LVL_W-1:LVL_W-4] == '0) begin
				m_q  <= {m_q[LVL_W-5:0], 4'd0};
				sh_q <= sh_q + SH_W'(4);
			end else if (m_q[LVL_W-1:LVL_W-2] == '0) begin
				m_q  <= {m_q[LVL_W-3:0], 2'd0};
				sh_q <= sh_q + SH_W'(2);
			end else begin
				m_q  <= {m_q[LVL_W-2:0], 1'b0};
				sh_q <= sh_q + SH_W'(1);
			end
		end else if (cmd.sq) begin
			// one fraction bit per squaring
			if (m_nx[LVL_W]) begin
				m_q    <= m_nx[LVL_W:1];
				frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
			end else begin
				m_q    <= m_nx[LVL_W-1:0];
				frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
			end
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(lg) * PROD_W'(k_s);
		end
	end

	// round half up, floor by 2^32, saturate
	assign rnd_sum = {prod_q[PROD_W-1], prod_q} + (RND_W'(1) <<< (RND_SHIFT - 1));
	assign db_full = rnd_sum[RND_W-1:RND_SHIFT];

	always_comb begin
		if (zero_q || (db_full < DBF_W'(DB_FLOOR))) begin
			db = DB_W'(DB_FLOOR);
		end else if (db_full > DBF_W'(DB_CEIL)) begin
			db = DB_W'(DB_CEIL);
		end else begin
			db = db_full[DB_W-1:0];
		end
	end

endmodule

// ===== hdl/alm_ctrl.sv =====
// ----------------------------------------------------------------------------
// alm_ctrl: sequencing controller for the level meter
// Steps one item through read/update, normalize, squaring, scale and
// result load, and stalls the input channel while an item is in work.
// ----------------------------------------------------------------------------
module alm_ctrl import alm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  alm_sts_t sts,
	output alm_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_NORM = 3'd2;
	localparam logic [2:0] S_SQ   = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]          state_q;
	logic [2:0]          state_nx;
	logic [SQ_CNT_W-1:0] cnt_q;

	assign in_stall = (state_q != S_IDLE);

	// commands
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	assign cmd.upd    = (state_q == S_UPD);
	assign cmd.norm   = (state_q == S_NORM);
	assign cmd.sq     = (state_q == S_SQ);
	assign cmd.mul    = (state_q == S_MUL);
	assign cmd.fin    = (state_q == S_FIN) && sts.out_room;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_nx = S_UPD;
			S_UPD:  state_nx = S_NORM;
			S_NORM: if (sts.norm_done) state_nx = S_SQ;
			S_SQ:   if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) state_nx = S_MUL;
			S_MUL:  state_nx = S_FIN;
			S_FIN:  if (sts.out_room) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			// squaring step counter
			if (state_q == S_SQ) begin
				cnt_q <= cnt_q + SQ_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== hdl/alm_datapath.sv =====
// ----------------------------------------------------------------------------
// alm_datapath: envelope and hold storage, ballistics and dB conversion
// Holds the per-channel memories with valid bits, the decay coefficient,
// the item registers, two converters and the result register.
// ----------------------------------------------------------------------------
module alm_datapath import alm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  alm_cmd_t                 cmd,
	output alm_sts_t                 sts,
	input  logic                     cfg_we,
	input  logic [COEFF_W-1:0]       cfg_data,
	input  logic                     opcode,
	input  logic [CHAN_W-1:0]        channel,
	input  logic [LVL_W-1:0]         peak_level,
	input  logic [LVL_W-1:0]         rms_level,
	input  logic                     clip_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CHAN_W-1:0]        out_channel,
	output logic signed [DB_W-1:0]   peak_db,
	output logic signed [DB_W-1:0]   rms_db,
	output logic signed [DB_W-1:0]   hold_db,
	output logic                     clip_out
);

	// gap close: env - ceil((env - lvl) * coeff / 2^16), or jump up
	function automatic logic [LVL_W-1:0] ballistics(
		input logic [LVL_W-1:0]   env,
		input logic [LVL_W-1:0]   lvl,
		input logic [COEFF_W-1:0] coeff
	);
		logic [LVL_W-1:0]         gap;
		logic [LVL_W+COEFF_W:0]   prod;
		logic [LVL_W-1:0]         drop;
		begin
			gap  = env - lvl;
			prod = (LVL_W+COEFF_W+1)'(gap) * (LVL_W+COEFF_W+1)'(coeff)
				+ (LVL_W+COEFF_W+1)'({COEFF_W{1'b1}});
			drop = prod[LVL_W+COEFF_W-1:COEFF_W];
			if (lvl > env) begin
				ballistics = lvl;
			end else begin
				ballistics = env - drop;
			end
		end
	endfunction

	logic [COEFF_W-1:0]  coeff_q;

	// item registers
	logic                op_q;
	logic [CHAN_W-1:0]   ch_q;
	logic [LVL_W-1:0]    pk_q;
	logic [LVL_W-1:0]    rm_q;
	logic                clip_q;

	// memories and valid bits
	alm_env_t            env_mem [CHANNELS];
	logic [DB_W-1:0]     hold_mem [CHANNELS];
	logic [CHANNELS-1:0] env_vld_q;
	logic [CHANNELS-1:0] hold_vld_q;
	alm_env_t            env_rd_q;
	logic                env_rd_vld_q;
	logic [DB_W-1:0]     hold_rd_q;
	logic                hold_rd_vld_q;

	logic                clip_cur_q;
	logic                out_valid_q;

	logic                in_range;
	logic [IDX_W-1:0]    idx;
	alm_env_t            env_cur;
	alm_env_t            env_new;
	logic [LVL_W-1:0]    pk_load;
	logic [LVL_W-1:0]    rm_load;
	logic                env_we;
	logic                pk_done;
	logic                rm_done;
	logic signed [DB_W-1:0] pdb;
	logic signed [DB_W-1:0] rdb;
	logic signed [DB_W-1:0] hold_cur;
	logic signed [DB_W-1:0] hold_new;
	logic                hold_we;

	assign in_range = ({1'b0, ch_q} < CHAN_CMP_W'(CHANNELS));
	assign idx      = ch_q[IDX_W-1:0];

	// coefficient register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RESET;
		end else if (cfg_we) begin
			coeff_q <= cfg_data;
		end
	end

	// capture the item and read its channel's entries
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= opcode;
			ch_q     <= channel;
			pk_q     <= peak_level;
			rm_q     <= rms_level;
			clip_q   <= clip_in;
			env_rd_q <= env_mem[channel[IDX_W-1:0]];
			hold_rd_q <= hold_mem[channel[IDX_W-1:0]];
		end
		if (env_we) begin
			env_mem[idx] <= env_new;
		end
		if (hold_we) begin
			hold_mem[idx] <= hold_new;
		end
	end

	// envelope update, a never-written entry reads as zero
	always_comb begin
		env_cur = env_rd_vld_q ? env_rd_q : '0;
		env_new.peak = ballistics(env_cur.peak, pk_q, coeff_q);
		env_new.rms  = ballistics(env_cur.rms, rm_q, coeff_q);
		env_new.clip = env_cur.clip | clip_q;
	end

	assign env_we  = cmd.upd && in_range && (op_q == OP_UPDATE);
	assign pk_load = (op_q == OP_UPDATE) ? env_new.peak : env_cur.peak;
	assign rm_load = (op_q == OP_UPDATE) ? env_new.rms : env_cur.rms;

	// peak hold
	assign hold_cur = hold_rd_vld_q ? hold_rd_q : DB_W'(DB_FLOOR);
	assign hold_new = (pdb > hold_cur) ? pdb : hold_cur;
	assign hold_we  = cmd.fin && in_range && (op_q == OP_UPDATE);

	// valid bits and clip of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_vld_q     <= '0;
			hold_vld_q    <= '0;
			env_rd_vld_q  <= 1'b0;
			hold_rd_vld_q <= 1'b0;
			clip_cur_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				env_rd_vld_q  <= env_vld_q[channel[IDX_W-1:0]];
				hold_rd_vld_q <= hold_vld_q[channel[IDX_W-1:0]];
			end
			if (env_we) begin
				env_vld_q[idx] <= 1'b1;
			end
			if (cmd.upd) begin
				clip_cur_q <= (op_q == OP_UPDATE) ? env_new.clip : env_cur.clip;
			end
			if (cmd.fin && (op_q == OP_CLEAR)) begin
				hold_vld_q <= '0;
			end else if (hold_we) begin
				hold_vld_q[idx] <= 1'b1;
			end
		end
	end

	alm_log_unit u_log_pk (
		.clk      (clk),
		.cmd      (cmd),
		.load_val (pk_load),
		.done     (pk_done),
		.db       (pdb)
	);

	alm_log_unit u_log_rm (
		.clk      (clk),
		.cmd      (cmd),
		.load_val (rm_load),
		.done     (rm_done),
		.db       (rdb)
	);

	assign sts.norm_done = pk_done & rm_done;
	assign sts.out_room  = !out_valid_q || !out_stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_channel <= ch_q;
			if (!in_range) begin
				peak_db  <= DB_W'(DB_FLOOR);
				rms_db   <= DB_W'(DB_FLOOR);
				hold_db  <= DB_W'(DB_FLOOR);
				clip_out <= 1'b0;
			end else begin
				peak_db  <= pdb;
				rms_db   <= rdb;
				hold_db  <= (op_q == OP_CLEAR) ? DB_W'(DB_FLOOR) : hold_new;
				clip_out <= clip_cur_q;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/audio_level_meter_ballistics.sv =====
// ----------------------------------------------------------------------------
// audio_level_meter_ballistics: multichannel meter with peak hold
// An item passes update, normalize, squaring, scale and result load; normalize varies with the level.
// It takes one item at a time; the 16 squaring steps of the log units dominate, and result load waits on out_stall.
// Reset clears control, sets decay_coeff to 5240; envelopes and holds read as reset at once.
// ----------------------------------------------------------------------------
module audio_level_meter_ballistics import alm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [COEFF_W-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [CHAN_W-1:0]      channel,
	input  logic [LVL_W-1:0]       peak_level,
	input  logic [LVL_W-1:0]       rms_level,
	input  logic                   clip_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CHAN_W-1:0]      out_channel,
	output logic signed [DB_W-1:0] peak_db,
	output logic signed [DB_W-1:0] rms_db,
	output logic signed [DB_W-1:0] hold_db,
	output logic                   clip_out
);

	alm_cmd_t cmd;
	alm_sts_t sts;

	// coefficient writes are always accepted
	assign cfg_ready = 1'b1;

	alm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	alm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.channel     (channel),
		.peak_level  (peak_level),
		.rms_level   (rms_level),
		.clip_in     (clip_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.peak_db     (peak_db),
		.rms_db      (rms_db),
		.hold_db     (hold_db),
		.clip_out    (clip_out)
	);

	// one item at a time: the cycle after a transfer the input is stalled
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in work");

	// results are loaded only while an item is in work
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// converted peak and hold levels stay within the display range
	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (peak_db >= DB_W'(DB_FLOOR)) && (peak_db <= DB_W'(DB_CEIL))
			&& (hold_db >= DB_W'(DB_FLOOR)) && (hold_db <= DB_W'(DB_CEIL)))
		else $error("dB result outside display range");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multichannel meter ballistics
// Drives update and clear items through the valid/stall input channel, predicts
// each channel's envelopes, dB values, peak hold and clip latch, and compares
// every output transfer in order. The decay coefficient is rewritten between
// phases, and both channels idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb_top;
	import alm_pkg::*;

	localparam int NCH = 64;
	localparam int RAND_PER_PHASE = 215;
	localparam int PHASES = 6;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG = 4000;
	localparam logic [COEFF_W-1:0] COEFF_AT_RESET = 16'd5240;
	localparam longint DB_SCALE = 101008905;
	localparam logic signed [DB_W-1:0] DB_MIN = -16'sd25600;
	localparam logic signed [DB_W-1:0] DB_TOP = 16'sd1541;
	localparam logic signed [DB_W-1:0] DB_HALF = -16'sd1541;

	// one displayed meter line
	typedef struct packed {
		logic [CHAN_W-1:0]      chan;
		logic signed [DB_W-1:0] peak;
		logic signed [DB_W-1:0] rms;
		logic signed [DB_W-1:0] hold;
		logic                   clip;
	} meter_disp_t;

	// one stimulus item, with an optional hand-written expectation
	typedef struct packed {
		logic              op;
		logic [CHAN_W-1:0] ch;
		logic [LVL_W-1:0]  pk;
		logic [LVL_W-1:0]  rm;
		logic              clip;
		logic              typed;
		meter_disp_t       want;
	} meter_item_t;

	localparam int DIR_ROWS = 20;
	meter_item_t dir_tab [DIR_ROWS] = '{
		'{OP_UPDATE, 6'd0,  24'h000000, 24'h000000, 1'b0, 1'b1, '{6'd0, DB_MIN, DB_MIN, DB_MIN, 1'b0}},
		'{OP_UPDATE, 6'd1,  24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, '{6'd1, DB_TOP, DB_TOP, DB_TOP, 1'b1}},
		'{OP_UPDATE, 6'd2,  24'h800000, 24'h400000, 1'b0, 1'b1, '{6'd2, 16'sd0, DB_HALF, 16'sd0, 1'b0}},
		'{OP_UPDATE, 6'd3,  24'h000001, 24'h000001, 1'b0, 1'b1, '{6'd3, DB_MIN, DB_MIN, DB_MIN, 1'b0}},
		'{OP_UPDATE, 6'd63, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1, '{6'd63, DB_TOP, DB_MIN, DB_TOP, 1'b1}},
		'{OP_CLEAR,  6'd1,  24'h123456, 24'h654321, 1'b1, 1'b1, '{6'd1, DB_TOP, DB_TOP, DB_MIN, 1'b1}},
		'{OP_CLEAR,  6'd0,  24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, '{6'd0, DB_MIN, DB_MIN, DB_MIN, 1'b0}},
		'{OP_UPDATE, 6'd1,  24'h000000, 24'h000000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd1,  24'h000000, 24'h000000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd1,  24'hFFFFFF, 24'h000000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd2,  24'h800000, 24'h800000, 1'b0, 1'b1, '{6'd2, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
		'{OP_UPDATE, 6'd2,  24'h400000, 24'h400000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd3,  24'h000100, 24'h000000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd5,  24'h555555, 24'hAAAAAA, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd5,  24'hAAAAAA, 24'h555555, 1'b1, 1'b0, '0},
		'{OP_CLEAR,  6'd5,  24'h000000, 24'h000000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd62, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd1,  24'h000000, 24'h000000, 1'b0, 1'b0, '0},
		'{OP_UPDATE, 6'd40, 24'h000080, 24'hFFFF00, 1'b1, 1'b0, '0},
		'{OP_UPDATE, 6'd5,  24'h000000, 24'h000000, 1'b0, 1'b0, '0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [COEFF_W-1:0]     cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   opcode;
	logic [CHAN_W-1:0]      channel;
	logic [LVL_W-1:0]       peak_level;
	logic [LVL_W-1:0]       rms_level;
	logic                   clip_in;
	logic                   out_valid;
	logic                   out_stall;
	logic [CHAN_W-1:0]      out_channel;
	logic signed [DB_W-1:0] peak_db;
	logic signed [DB_W-1:0] rms_db;
	logic signed [DB_W-1:0] hold_db;
	logic                   clip_out;

	// predicted meter state
	logic [COEFF_W-1:0]     decay_coeff;
	logic [LVL_W-1:0]       peak_env [NCH];
	logic [LVL_W-1:0]       rms_env [NCH];
	logic                   clip_lat [NCH];
	logic signed [DB_W-1:0] hold_lvl [NCH];

	meter_disp_t display_q [$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;

	audio_level_meter_ballistics u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.channel    (channel),
		.peak_level (peak_level),
		.rms_level  (rms_level),
		.clip_in    (clip_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_channel(out_channel),
		.peak_db    (peak_db),
		.rms_db     (rms_db),
		.hold_db    (hold_db),
		.clip_out   (clip_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// envelope follows rises at once, closes a coefficient share of a falling gap
	function automatic logic [LVL_W-1:0] decay_toward(input logic [LVL_W-1:0] env,
			input logic [LVL_W-1:0] lvl);
		logic [63:0] drop;
		if (lvl > env)
			return lvl;
		drop = (64'(env - lvl) * 64'(decay_coeff) + 64'd65535) >> 16;
		return env - drop[LVL_W-1:0];
	endfunction

	// log2 by repeated squaring, scaled to 1/256 dB and saturated
	function automatic logic signed [DB_W-1:0] level_db(input logic [LVL_W-1:0] v);
		int msb;
		int i;
		logic [63:0] m;
		logic [15:0] frac;
		longint lg;
		longint db;
		if (v == '0)
			return DB_MIN;
		msb = LVL_W - 1;
		while (msb > 0 && v[msb] == 1'b0)
			msb--;
		m = 64'(v) << (23 - msb);
		frac = '0;
		for (i = 0; i < 16; i++) begin
			m = (m * m) >> 23;
			frac = frac << 1;
			if (m >= (64'd1 << 24)) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		lg = longint'(msb - 23) * 65536 + longint'(frac);
		db = (lg * DB_SCALE + (longint'(1) << 31)) >>> 32;
		if (db < DB_MIN)
			return DB_MIN;
		if (db > DB_TOP)
			return DB_TOP;
		return db[DB_W-1:0];
	endfunction

	// apply one item to the predicted state and form its display line
	task automatic meter_update(input meter_item_t it, output meter_disp_t res);
		int i;
		if (it.op == OP_CLEAR) begin
			for (i = 0; i < NCH; i++)
				hold_lvl[i] = DB_MIN;
		end else begin
			peak_env[it.ch] = decay_toward(peak_env[it.ch], it.pk);
			rms_env[it.ch] = decay_toward(rms_env[it.ch], it.rm);
			if (it.clip)
				clip_lat[it.ch] = 1'b1;
		end
		res.chan = it.ch;
		res.peak = level_db(peak_env[it.ch]);
		res.rms = level_db(rms_env[it.ch]);
		if (it.op == OP_UPDATE && res.peak > hold_lvl[it.ch])
			hold_lvl[it.ch] = res.peak;
		res.hold = hold_lvl[it.ch];
		res.clip = clip_lat[it.ch];
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want, input logic [CHAN_W-1:0] ch);
		if (got !== want)
			report_mismatch($sformatf("ch %0d %s got %0d expected %0d",
				ch, name, $signed(got), $signed(want)));
	endtask

	// level mix: zero, full scale, powers of two, wide and shifted-down values
	function automatic logic [LVL_W-1:0] pick_level();
		logic [LVL_W-1:0] r;
		r = LVL_W'($urandom);
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return LVL_W'(1) << $urandom_range(LVL_W - 1);
			3, 4: return r;
			default: return r >> $urandom_range(LVL_W - 1);
		endcase
	endfunction

	// offer one item, hold it until the transfer, then record its expectation
	task automatic send_item(input meter_item_t it);
		meter_disp_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.op;
		channel <= it.ch;
		peak_level <= it.pk;
		rms_level <= it.rm;
		clip_in <= it.clip;
		do
			@(posedge clk);
		while (in_stall);
		meter_update(it, pred);
		display_q.push_back(it.typed ? it.want : pred);
		@(negedge clk);
	endtask

	// stop offering until every expected line has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (display_q.size() != 0);
	endtask

	task automatic write_coeff(input logic [COEFF_W-1:0] value);
		wait_drained();
		repeat (30) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		decay_coeff = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// main sequence
	initial begin
		meter_item_t it;
		int phase;
		int k;
		int i;
		logic [COEFF_W-1:0] coeff_plan [PHASES];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_UPDATE;
		channel = '0;
		peak_level = '0;
		rms_level = '0;
		clip_in = 1'b0;
		mismatches = 0;
		hold_req = 1'b0;
		send_idle_pct = 32;
		recv_idle_pct = 66;
		decay_coeff = COEFF_AT_RESET;
		for (i = 0; i < NCH; i++) begin
			peak_env[i] = '0;
			rms_env[i] = '0;
			clip_lat[i] = 1'b0;
			hold_lvl[i] = DB_MIN;
		end
		coeff_plan = '{COEFF_AT_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(65535)),
			16'd1, 16'd32768};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items under the reset coefficient
		for (i = 0; i < DIR_ROWS; i++)
			send_item(dir_tab[i]);

		// random phases: each after the first sets a new coefficient and idle profile
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 66 : 0;
				recv_idle_pct = (phase < 2) ? 66 : (phase < 4) ? 32 : 0;
				write_coeff(coeff_plan[phase]);
			end
			for (k = 0; k < RAND_PER_PHASE; k++) begin
				if (phase == 1 && k == 20)
					hold_req = 1'b1;
				if (phase == 3 && k == 100)
					wait_drained();
				it = '0;
				it.op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_UPDATE;
				it.ch = ($urandom_range(99) < 60) ? CHAN_W'($urandom_range(3))
					: CHAN_W'($urandom_range(NCH - 1));
				it.pk = pick_level();
				it.rm = pick_level();
				it.clip = ($urandom_range(15) == 0);
				send_item(it);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (display_q.size() != 0)
			report_mismatch($sformatf("%0d expected lines never came", display_q.size()));
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		meter_disp_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (display_q.size() == 0) begin
				report_mismatch($sformatf("unexpected line for ch %0d", out_channel));
			end else begin
				want = display_q.pop_front();
				check_field("channel", 16'(out_channel), 16'(want.chan), want.chan);
				check_field("peak_db", peak_db, want.peak, want.chan);
				check_field("rms_db", rms_db, want.rms, want.chan);
				check_field("hold_db", hold_db, want.hold, want.chan);
				check_field("clip", 16'(clip_out), 16'(want.clip), want.chan);
			end
		end
	end

	// watchdog: quiet cycles with no transfer on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
					|| (cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", WATCHDOG);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/alm_pkg.sv
hdl/alm_log_unit.sv
hdl/alm_ctrl.sv
hdl/alm_datapath.sv
hdl/audio_level_meter_ballistics.sv
verif/tb_top.sv
